/* src/ptts_pkg.sv */
// Shared types, constants and control structs of the periodic task tick scheduler.
package ptts_pkg;

  localparam int TASK_SLOTS   = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int SLOT_W       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W        = $clog2(TASK_SLOTS + 1);
  localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);
  localparam int TASK_SLOT_W  = 6;
  localparam int TIME_W       = 32;
  localparam int PEND_W       = 8;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [TIME_W-1:0] first_delay;
    logic [TIME_W-1:0] period;
  } in_item_t;

  typedef struct packed {
    logic [TASK_SLOT_W-1:0] task_slot;
    logic                   fired;
    logic                   accepted;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] delay_left;
    logic [TIME_W-1:0] reload_period;
    logic [PEND_W-1:0] pending_runs;
  } slot_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD,
    ST_TICK,
    ST_DSCAN,
    ST_DUPD,
    ST_DNONE
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic scan_rst;
    logic clr_table;
    logic add_task;
    logic tick_step;
    logic disp_skip;
    logic disp_rd;
    logic disp_commit;
    logic none_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic cur_due;
    logic tick_done;
    logic emitted_zero;
  } dp_sts_t;

endpackage

/* src/ptts_ctrl.sv */
// Controller state machine that sequences clear, add, tick and dispatch.
module ptts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptts_pkg::func_t   in_func,
  input  ptts_pkg::dp_sts_t sts,
  output ptts_pkg::dp_cmd_t cmd
);
  import ptts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_CLEAR:    state_nxt = ST_CLEAR;
            FUNC_ADD:      state_nxt = ST_ADD;
            FUNC_TICK:     state_nxt = ST_TICK;
            FUNC_DISPATCH: state_nxt = ST_DSCAN;
          endcase
        end
      end
      ST_CLEAR: state_nxt = ST_IDLE;
      ST_ADD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (sts.tick_done) state_nxt = ST_IDLE;
      end
      ST_DSCAN: begin
        priority if (sts.scan_end) begin
          state_nxt = sts.emitted_zero ? ST_DNONE : ST_IDLE;
        end else if (sts.cur_due) begin
          state_nxt = ST_DUPD;
        end
      end
      ST_DUPD: begin
        if (sts.out_free) state_nxt = ST_DSCAN;
      end
      ST_DNONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.cap_in   = in_valid;
        cmd.scan_rst = in_valid;
      end
      ST_CLEAR: cmd.clr_table = 1'b1;
      ST_ADD:   cmd.add_task  = sts.out_free;
      ST_TICK:  cmd.tick_step = 1'b1;
      ST_DSCAN: begin
        // A slot that is not due is skipped; a due slot needs a memory read.
        if (!sts.scan_end) begin
          cmd.disp_rd   = sts.cur_due;
          cmd.disp_skip = !sts.cur_due;
        end
      end
      ST_DUPD:  cmd.disp_commit = sts.out_free;
      ST_DNONE: cmd.none_emit   = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/ptts_dpath.sv */
// Datapath with the slot memory, slot flags, scan counters and output register.
module ptts_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::dp_cmd_t   cmd,
  output ptts_pkg::dp_sts_t   sts,
  input  ptts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptts_pkg::out_item_t out_data
);
  import ptts_pkg::*;

  slot_entry_t             slot_mem [TASK_SLOTS];
  slot_entry_t             rd_data_r;
  in_item_t                in_r;
  out_item_t               out_r;
  logic                    out_valid_r;
  logic [TASK_SLOTS-1:0]   slot_valid_r;
  logic [TASK_SLOTS-1:0]   due_r;
  logic [CNT_W-1:0]        slots_used_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [EMIT_W-1:0]       emitted_r;
  logic                    tick_v_r;
  logic [SLOT_W-1:0]       tick_idx_r;

  logic [SLOT_W-1:0]       cur_idx;
  logic [SLOT_W-1:0]       add_idx;
  logic                    in_range;
  logic                    full;
  logic                    out_free;
  logic                    higher_due;
  logic                    last_la;
  logic                    tick_reload;
  logic [PEND_W-1:0]       pend_dec;
  logic                    one_shot;
  slot_entry_t             tick_entry;
  logic                    mem_we;
  logic                    mem_re;
  logic [SLOT_W-1:0]       mem_waddr;
  slot_entry_t             mem_wdata;

  assign cur_idx  = cnt_r[SLOT_W-1:0];
  assign add_idx  = slots_used_r[SLOT_W-1:0];
  assign in_range = (cnt_r < slots_used_r);
  assign full     = (slots_used_r == CNT_W'(TASK_SLOTS));
  assign out_free = !out_valid_r || out_ready;

  // Tick: a running countdown steps down, an expired one reloads and books a run.
  assign tick_reload = (rd_data_r.delay_left == '0);
  always_comb begin
    tick_entry = rd_data_r;
    if (tick_reload) begin
      tick_entry.delay_left = rd_data_r.reload_period;
      if (rd_data_r.pending_runs != PEND_MAX) begin
        tick_entry.pending_runs = rd_data_r.pending_runs + 1'b1;
      end
    end else begin
      tick_entry.delay_left = rd_data_r.delay_left - 1'b1;
    end
  end

  assign pend_dec = rd_data_r.pending_runs - 1'b1;
  assign one_shot = (rd_data_r.reload_period == '0);

  // The current result is the last one when no due slot lies above it or it fills the result limit.
  always_comb begin
    higher_due = 1'b0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (j > int'(cur_idx)) higher_due = higher_due | due_r[j];
    end
  end
  assign last_la = !higher_due || (emitted_r == EMIT_W'(RESULT_LIMIT - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = rd_data_r;
    priority if (cmd.add_task && !full) begin
      mem_we    = 1'b1;
      mem_waddr = add_idx;
      mem_wdata = '{delay_left: in_r.first_delay, reload_period: in_r.period,
                    pending_runs: '0};
    end else if (tick_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = tick_idx_r;
      mem_wdata = tick_entry;
    end else if (cmd.disp_commit) begin
      mem_we                 = 1'b1;
      mem_wdata.pending_runs = pend_dec;
    end
  end
  assign mem_re = (cmd.tick_step && in_range) || cmd.disp_rd;

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= slot_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      due_r        <= '0;
      slots_used_r <= '0;
      cnt_r        <= '0;
      emitted_r    <= '0;
      tick_v_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      tick_v_r <= cmd.tick_step && in_range && slot_valid_r[cur_idx];
      if (tick_v_r && tick_reload) due_r[tick_idx_r] <= 1'b1;
      if (cmd.scan_rst) begin
        cnt_r     <= '0;
        emitted_r <= '0;
      end
      if ((cmd.tick_step && in_range) || cmd.disp_skip) cnt_r <= cnt_r + 1'b1;
      if (cmd.disp_commit) begin
        cnt_r          <= cnt_r + 1'b1;
        emitted_r      <= emitted_r + 1'b1;
        out_valid_r    <= 1'b1;
        due_r[cur_idx] <= (pend_dec != '0) && !one_shot;
        if (one_shot) slot_valid_r[cur_idx] <= 1'b0;
      end
      if (cmd.add_task) begin
        out_valid_r <= 1'b1;
        if (!full) begin
          slot_valid_r[add_idx] <= 1'b1;
          due_r[add_idx]        <= 1'b0;
          slots_used_r          <= slots_used_r + 1'b1;
        end
      end
      if (cmd.none_emit) out_valid_r <= 1'b1;
      if (cmd.clr_table) begin
        slot_valid_r <= '0;
        due_r        <= '0;
        slots_used_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) in_r <= in_data;
    // The slot read in this cycle is written back in the next cycle.
    if (cmd.tick_step) tick_idx_r <= cur_idx;
    priority if (cmd.add_task) begin
      out_r.task_slot <= full ? '0 : TASK_SLOT_W'(add_idx);
      out_r.fired     <= 1'b0;
      out_r.accepted  <= !full;
      out_r.last      <= 1'b1;
    end else if (cmd.disp_commit) begin
      out_r.task_slot <= TASK_SLOT_W'(cur_idx);
      out_r.fired     <= 1'b1;
      out_r.accepted  <= 1'b0;
      out_r.last      <= last_la;
    end else if (cmd.none_emit) begin
      out_r.task_slot <= '0;
      out_r.fired     <= 1'b0;
      out_r.accepted  <= 1'b0;
      out_r.last      <= 1'b1;
    end
  end

  assign sts.out_free     = out_free;
  assign sts.scan_end     = !in_range || (emitted_r == EMIT_W'(RESULT_LIMIT));
  assign sts.cur_due      = due_r[cur_idx];
  assign sts.tick_done    = !in_range && !tick_v_r;
  assign sts.emitted_zero = (emitted_r == '0);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/periodic_task_tick_scheduler.sv */
// Top level of the periodic task tick scheduler: controller plus datapath.
//
//   channel   direction   handshake              payload
//   in_       input       in_valid / in_ready    in_data   (ptts_pkg::in_item_t)
//   out_      output      out_valid / out_ready  out_data  (ptts_pkg::out_item_t)
//
// Clear passes through the clear state and gives no result; add loads the result register.
// During a tick the slot memory, which has one read and one write port, streams the
// slots through a read stage and a write-back stage.
// Dispatch scans the used slots until the result limit, with an update step per due
// slot and a result step when nothing is due. A stalled out_ready holds add and dispatch.
// Reset is synchronous; the slot memory needs no clearing pass.
module periodic_task_tick_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptts_pkg::out_item_t out_data
);
  import ptts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_data.func),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/ptts_checker.sv */
// Port-level checker for the periodic task tick scheduler and its bind.
module ptts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ptts_pkg::out_item_t out_data
);
  import ptts_pkg::*;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A dispatched run never claims a successful add.
  a_fired_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |-> !out_data.accepted)
    else $error("fired and accepted both set");

  // Only a dispatch with runs due produces more than one result.
  a_multi_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.fired)
    else $error("non-final result that is not a run");

  // A stored task names a real slot and ends its item.
  a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      out_data.last && (out_data.task_slot < TASK_SLOT_W'(TASK_SLOTS)))
    else $error("add result out of range");

  // Rejected adds and empty dispatches report slot zero.
  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted && !out_data.fired |-> out_data.task_slot == '0)
    else $error("empty result with nonzero slot");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

/* bench/periodic_task_tick_scheduler_tb.sv */
// Testbench for the periodic task tick scheduler with a task-table predictor.
module periodic_task_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptts_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  periodic_task_tick_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Predicted task table.
  logic [TIME_W-1:0] tbl_delay  [TASK_SLOTS];
  logic [TIME_W-1:0] tbl_period [TASK_SLOTS];
  logic [PEND_W-1:0] tbl_pend   [TASK_SLOTS];
  bit                tbl_valid  [TASK_SLOTS];
  int                tbl_used;

  out_item_t run_reports [$];

  int fail_count     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void free_slot(int s);
    tbl_delay[s]  = '0;
    tbl_period[s] = '0;
    tbl_pend[s]   = '0;
    tbl_valid[s]  = 1'b0;
  endfunction

  function automatic void clear_table();
    for (int s = 0; s < TASK_SLOTS; s++) free_slot(s);
    tbl_used = 0;
  endfunction

  // Applies one accepted operation to the predicted table and queues its reports.
  function automatic void schedule_step(in_item_t op);
    out_item_t rep;
    out_item_t runs [$];
    rep = '0;
    case (op.func)
      FUNC_CLEAR: clear_table();
      FUNC_ADD: begin
        rep.last = 1'b1;
        if (tbl_used < TASK_SLOTS) begin
          tbl_delay[tbl_used]  = op.first_delay;
          tbl_period[tbl_used] = op.period;
          tbl_pend[tbl_used]   = '0;
          tbl_valid[tbl_used]  = 1'b1;
          rep.task_slot        = TASK_SLOT_W'(tbl_used);
          rep.accepted         = 1'b1;
          tbl_used++;
        end
        run_reports.push_back(rep);
      end
      FUNC_TICK: begin
        for (int s = 0; s < tbl_used; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_delay[s] != '0) begin
              tbl_delay[s] = tbl_delay[s] - 1'b1;
            end else begin
              tbl_delay[s] = tbl_period[s];
              if (tbl_pend[s] != PEND_MAX) tbl_pend[s] = tbl_pend[s] + 1'b1;
            end
          end
        end
      end
      FUNC_DISPATCH: begin
        for (int s = 0; s < tbl_used && runs.size() < RESULT_LIMIT; s++) begin
          if (tbl_valid[s] && tbl_pend[s] != '0) begin
            tbl_pend[s]   = tbl_pend[s] - 1'b1;
            rep           = '0;
            rep.task_slot = TASK_SLOT_W'(s);
            rep.fired     = 1'b1;
            runs.push_back(rep);
            // A one-shot task gives its slot up after running.
            if (tbl_period[s] == '0) free_slot(s);
          end
        end
        if (runs.size() == 0) begin
          rep      = '0;
          rep.last = 1'b1;
          runs.push_back(rep);
        end else begin
          runs[runs.size()-1].last = 1'b1;
        end
        foreach (runs[k]) run_reports.push_back(runs[k]);
      end
      default: ;
    endcase
  endfunction

  // Offers one operation and waits for its transfer; valid stays high into the next call.
  task automatic send_op(func_t f, logic [TIME_W-1:0] d = '0, logic [TIME_W-1:0] p = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= in_item_t'{func: f, first_delay: d, period: p};
    do @(posedge clk); while (!in_ready);
    schedule_step(in_data);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (run_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] pick_time(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return '0;
    if (r < 85) return $urandom_range(6, 1);
    if (r < 93) return $urandom_range(1000);
    return $urandom();
  endfunction

  // Mostly adds with short timing, ticks and dispatches; now and then a clear.
  task automatic send_random_op();
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      send_op(FUNC_CLEAR, $urandom(), $urandom());
    end else if (r < ((tbl_used < TASK_SLOTS) ? 34 : 12)) begin
      send_op(FUNC_ADD, pick_time(25), pick_time(30));
    end else if (r < 66) begin
      send_op(FUNC_TICK, $urandom(), $urandom());
    end else begin
      send_op(FUNC_DISPATCH, $urandom(), $urandom());
    end
  endtask

  // Fills the table with extreme and one-shot tasks, overflows it, then runs it.
  task automatic test_table_full();
    send_op(FUNC_CLEAR);
    send_op(FUNC_ADD, '0, '0);
    send_op(FUNC_ADD, '0, 32'd1);
    send_op(FUNC_ADD, '1, '1);
    send_op(FUNC_ADD, 32'd1, '0);
    repeat (12) send_op(FUNC_ADD, $urandom_range(3), $urandom_range(3, 1));
    send_op(FUNC_ADD, 32'd5, 32'd5);
    send_op(FUNC_DISPATCH);
    send_op(FUNC_TICK);
    send_op(FUNC_DISPATCH);
    repeat (2) send_op(FUNC_TICK);
    send_op(FUNC_DISPATCH);
    send_op(FUNC_CLEAR);
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_output_hold();
    hold_left = 300;
    send_op(FUNC_CLEAR);
    repeat (TASK_SLOTS) send_op(FUNC_ADD, '0, 32'd1);
    repeat (3) send_op(FUNC_TICK);
    repeat (4) send_op(FUNC_DISPATCH);
    wait_drained();
  endtask

  task automatic test_random_phase(int n_ops, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_ops) send_random_op();
    wait_drained();
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (run_reports.size() == 0) begin
        $error("unexpected result: task_slot %0d fired %0b accepted %0b last %0b",
               out_data.task_slot, out_data.fired, out_data.accepted, out_data.last);
        fail_count++;
      end else begin
        want = run_reports.pop_front();
        if (out_data.task_slot !== want.task_slot) begin
          $error("task_slot: expected %0d, got %0d", want.task_slot, out_data.task_slot);
          fail_count++;
        end
        if (out_data.fired !== want.fired) begin
          $error("fired: expected %0b, got %0b", want.fired, out_data.fired);
          fail_count++;
        end
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_data.accepted);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_table();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_table_full();
    test_output_hold();
    test_random_phase(58, 0, 0);
    test_random_phase(58, 71, 0);
    test_random_phase(58, 0, 71);
    test_random_phase(58, 26, 26);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* periodic_task_tick_scheduler.f */
src/ptts_pkg.sv
src/ptts_ctrl.sv
src/ptts_dpath.sv
src/periodic_task_tick_scheduler.sv
src/ptts_checker.sv
bench/periodic_task_tick_scheduler_tb.sv
